[rtl/arcp_pkg.sv]
`timescale 1ns / 1ps

package arcp_pkg;

  // Largest corner radius the datapath is sized for by default.
  localparam int MAX_RADIUS_DEF = 64;

  // Configuration space: 5 registers, 32-bit words.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_RADIUS           = 3'd0;
  localparam logic [2:0] REG_RING_THICKNESS   = 3'd1;
  localparam logic [2:0] REG_FILL_COLOR       = 3'd2;
  localparam logic [2:0] REG_BORDER_COLOR     = 3'd3;
  localparam logic [2:0] REG_BACKGROUND_COLOR = 3'd4;

  localparam logic [6:0]  RADIUS_RST     = 7'd8;
  localparam logic [6:0]  THICKNESS_RST  = 7'd1;
  localparam logic [23:0] FILL_RST       = 24'hFFFFFF;
  localparam logic [23:0] BORDER_RST     = 24'h000000;
  localparam logic [23:0] BACKGROUND_RST = 24'h000000;

  // Offsets are in half pixels: dist_q8 = sqrt(d2 / 4) * 256 = sqrt(d2 << 14).
  localparam int RADICAND_SHIFT = 14;

  // Coverage is 0..256 in 1/256 steps.
  localparam int          COV_W   = 9;
  localparam logic [8:0]  COV_ONE = 9'd256;
  localparam logic [7:0]  ALPHA   = 8'hFF;

  typedef struct packed {
    logic [23:0] fill;
    logic [23:0] border;
    logic [23:0] background;
  } color_cfg_t;

endpackage

[rtl/arcp_dist.sv]
`timescale 1ns / 1ps

// Squared distance from pixel center to tile center, in quarter-pixel units.
// Three stages: offsets, squares, sum.
module arcp_dist #(
  parameter int RW    = 7,
  parameter int MAG_W = 8,
  parameter int D2_W  = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  input  logic [6:0]      x_i,
  input  logic [6:0]      y_i,
  input  logic [RW-1:0]   r_eff_i,
  output logic            valid_o,
  output logic [D2_W-1:0] d2_o
);
  import arcp_pkg::*;

  localparam int DX_W = MAG_W + 1;
  localparam int SQ_W = 2 * MAG_W;

  logic [2:0] v_r;

  logic signed [DX_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [2*DX_W-1:0] px, py;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic [D2_W-1:0] d2_r, d2_nxt;

  always_comb begin
    dx_nxt = $signed(DX_W'({x_i, 1'b1})) - $signed(DX_W'({r_eff_i, 1'b0}));
    dy_nxt = $signed(DX_W'({y_i, 1'b1})) - $signed(DX_W'({r_eff_i, 1'b0}));
    px     = dx_r * dx_r;
    py     = dy_r * dy_r;
    d2_nxt = D2_W'(sqx_r) + D2_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sqx_r <= px[SQ_W-1:0];
    sqy_r <= py[SQ_W-1:0];
    d2_r  <= d2_nxt;
  end

  assign valid_o = v_r[2];
  assign d2_o    = d2_r;

endmodule

[rtl/arcp_sqrt.sv]
`timescale 1ns / 1ps

// Pipelined restoring square root, one result bit per stage.
module arcp_sqrt #(
  parameter int N = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  logic [2*N-1:0] rad_i,
  output logic           valid_o,
  output logic [N-1:0]   root_o
);
  import arcp_pkg::*;

  localparam int REM_W = N + 2;

  logic [N-1:0]     v_r;
  logic [REM_W-1:0] rem_r  [N];
  logic [N-1:0]     root_r [N];
  logic [2*N-1:0]   rad_r  [N-1];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [REM_W-1:0] cur_rem, rem_sh, trial, rem_nxt;
    logic [N-1:0]     cur_root, root_nxt;
    logic [2*N-1:0]   cur_rad;
    logic             ge;

    if (g == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = rad_i;
    end else begin : g_next
      assign cur_rem  = rem_r[g-1];
      assign cur_root = root_r[g-1];
      assign cur_rad  = rad_r[g-1];
    end

    always_comb begin
      // remainder stays below 2^N before the shift
      rem_sh   = {cur_rem[REM_W-3:0], cur_rad[2*N-1 -: 2]};
      trial    = {cur_root, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {cur_root[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
    end

    if (g < N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        rad_r[g] <= {cur_rad[2*N-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[N-2:0], valid_i};
    end
  end

  assign valid_o = v_r[N-1];
  assign root_o  = root_r[N-1];

`ifndef NO_ASSERTIONS
  // floor sqrt: what is left over never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> (rem_r[N-1] <= REM_W'({root_r[N-1], 1'b0})))
    else $error("sqrt remainder out of range");
`endif

endmodule

[rtl/arcp_shade.sv]
`timescale 1ns / 1ps

// Coverage at both edges, then two color blends and the output register.
module arcp_shade #(
  parameter int RW     = 7,
  parameter int DIST_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic [DIST_W-1:0]    dist_i,
  input  logic [RW-1:0]        outer_edge_i,
  input  logic [RW-1:0]        inner_edge_i,
  input  arcp_pkg::color_cfg_t colors_i,
  output logic                 valid_o,
  output logic [31:0]          pixel_o
);
  import arcp_pkg::*;

  localparam int CV_W = DIST_W + 2;

  function automatic logic [COV_W-1:0] coverage(input logic [RW-1:0] edge_px,
                                                input logic [DIST_W-1:0] dist_q8);
    logic signed [CV_W-1:0] c;
    logic [COV_W-1:0]       res;
    c = $signed(CV_W'({edge_px, 8'h80})) - $signed(CV_W'(dist_q8));
    if (c[CV_W-1]) begin
      res = '0;
    end else if (c > $signed(CV_W'(COV_ONE))) begin
      res = COV_ONE;
    end else begin
      res = c[COV_W-1:0];
    end
    return res;
  endfunction

  // per channel: (b*256 + (t-b)*w + 128) >> 8, never negative
  function automatic logic [23:0] mix(input logic [23:0] base,
                                      input logic [23:0] over,
                                      input logic [COV_W-1:0] w);
    logic signed [8:0]  diff;
    logic signed [18:0] prod;
    logic signed [18:0] acc;
    logic [23:0]        res;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = $signed({1'b0, over[8*ch +: 8]}) - $signed({1'b0, base[8*ch +: 8]});
      prod = diff * $signed({1'b0, w});
      acc  = $signed({3'b000, base[8*ch +: 8], 8'h80}) + prod;
      res[8*ch +: 8] = acc[15:8];
    end
    return res;
  endfunction

  logic             va_r, vb_r, vc_r;
  logic [COV_W-1:0] shape_r, inner_r, inner_b_r;
  logic [23:0]      mix1_r, mix2;
  logic [31:0]      pixel_r;

  assign mix2 = mix(mix1_r, colors_i.fill, inner_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    shape_r   <= coverage(outer_edge_i, dist_i);
    inner_r   <= coverage(inner_edge_i, dist_i);
    mix1_r    <= mix(colors_i.background, colors_i.border, shape_r);
    inner_b_r <= inner_r;
    // 0x00BBGGRR in, 0xFFRRGGBB out
    pixel_r   <= {ALPHA, mix2[7:0], mix2[15:8], mix2[23:16]};
  end

  assign valid_o = vc_r;
  assign pixel_o = pixel_r;

`ifndef NO_ASSERTIONS
  // inner edge never lies outside the outer edge
  a_inner_le_shape: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (inner_r <= shape_r))
    else $error("inner coverage exceeds outer coverage");

  a_outside_is_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && (shape_r == '0)) |=> (mix1_r == colors_i.background))
    else $error("uncovered pixel did not keep background");

  a_inside_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && (inner_b_r == COV_ONE)) |=>
      (pixel_o == {ALPHA, colors_i.fill[7:0], colors_i.fill[15:8], colors_i.fill[23:16]}))
    else $error("fully covered pixel is not fill color");
`endif

endmodule

[rtl/antialiased_ring_tile_pixel_unit.sv]
`timescale 1ns / 1ps

// Anti-aliased ring tile pixel unit. Give a tile pixel (in_pixel_x, in_pixel_y)
// with start; busy is always low, so a pixel can be issued every clock and the
// unit sustains one pixel per cycle. Each item comes back on out_dib_pixel
// (0xFFRRGGBB) with a one-cycle out_strobe, in issue order, once it has passed
// the squared-distance stages, the square root and the shading stages. The
// square root has N result bits (16 at the default MAX_RADIUS of 64) and
// resolves one bit per pipeline stage; three stages form the squared distance
// ahead of it and three more do coverage and the two blends. Results cannot be
// held off; take them when the strobe is high. Registers are to be written by
// the user through the APB port only while no item is in flight; the unit does not enforce this.
module antialiased_ring_tile_pixel_unit #(
  parameter int MAX_RADIUS = arcp_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item input
  input  logic                        start,
  output logic                        busy,
  input  logic [6:0]                  in_pixel_x,
  input  logic [6:0]                  in_pixel_y,
  // result
  output logic                        out_strobe,
  output logic [31:0]                 out_dib_pixel,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arcp_pkg::ADDR_W-1:0] paddr,
  input  logic [arcp_pkg::DATA_W-1:0] pwdata,
  output logic [arcp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import arcp_pkg::*;

  localparam int ABS_MAX = (2 * MAX_RADIUS - 1 > 253) ? 2 * MAX_RADIUS - 1 : 253;
  localparam int MAG_W   = $clog2(ABS_MAX + 1);
  localparam int D2_W    = 2 * MAG_W + 1;
  localparam int SQ_N    = (D2_W + RADICAND_SHIFT + 1) / 2;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int CMP_W   = (RW > 7) ? RW : 7;

  logic [6:0]  cfg_radius_r, cfg_thickness_r;
  logic [23:0] cfg_fill_r, cfg_border_r, cfg_background_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radius_r     <= RADIUS_RST;
      cfg_thickness_r  <= THICKNESS_RST;
      cfg_fill_r       <= FILL_RST;
      cfg_border_r     <= BORDER_RST;
      cfg_background_r <= BACKGROUND_RST;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_RADIUS:           cfg_radius_r     <= pwdata[6:0];
        REG_RING_THICKNESS:   cfg_thickness_r  <= pwdata[6:0];
        REG_FILL_COLOR:       cfg_fill_r       <= pwdata[23:0];
        REG_BORDER_COLOR:     cfg_border_r     <= pwdata[23:0];
        REG_BACKGROUND_COLOR: cfg_background_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RADIUS:           prdata = DATA_W'(cfg_radius_r);
      REG_RING_THICKNESS:   prdata = DATA_W'(cfg_thickness_r);
      REG_FILL_COLOR:       prdata = DATA_W'(cfg_fill_r);
      REG_BORDER_COLOR:     prdata = DATA_W'(cfg_border_r);
      REG_BACKGROUND_COLOR: prdata = DATA_W'(cfg_background_r);
      default:              prdata = '0;
    endcase
  end

  // radius clamped to 1..MAX_RADIUS, thickness clamped to the radius
  logic [CMP_W-1:0] rad_ext, thk_ext, r_ext;
  logic [RW-1:0]    r_eff, t_eff, inner_edge;

  always_comb begin
    rad_ext = CMP_W'(cfg_radius_r);
    thk_ext = CMP_W'(cfg_thickness_r);
    if (rad_ext == '0) begin
      r_ext = CMP_W'(1);
    end else if (rad_ext > CMP_W'(MAX_RADIUS)) begin
      r_ext = CMP_W'(MAX_RADIUS);
    end else begin
      r_ext = rad_ext;
    end
    r_eff      = r_ext[RW-1:0];
    t_eff      = (thk_ext > r_ext) ? r_eff : thk_ext[RW-1:0];
    inner_edge = r_eff - t_eff;
  end

  logic            d2_valid;
  logic [D2_W-1:0] d2;
  logic            dist_valid;
  logic [SQ_N-1:0] dist_q8;
  color_cfg_t      colors;

  assign colors = '{fill: cfg_fill_r, border: cfg_border_r, background: cfg_background_r};

  arcp_dist #(
    .RW    (RW),
    .MAG_W (MAG_W),
    .D2_W  (D2_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .x_i     (in_pixel_x),
    .y_i     (in_pixel_y),
    .r_eff_i (r_eff),
    .valid_o (d2_valid),
    .d2_o    (d2)
  );

  arcp_sqrt #(
    .N (SQ_N)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (d2_valid),
    .rad_i   ((2*SQ_N)'({d2, {RADICAND_SHIFT{1'b0}}})),
    .valid_o (dist_valid),
    .root_o  (dist_q8)
  );

  arcp_shade #(
    .RW     (RW),
    .DIST_W (SQ_N)
  ) u_shade (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (dist_valid),
    .dist_i       (dist_q8),
    .outer_edge_i (r_eff),
    .inner_edge_i (inner_edge),
    .colors_i     (colors),
    .valid_o      (out_strobe),
    .pixel_o      (out_dib_pixel)
  );

endmodule

[tb/antialiased_ring_tile_pixel_unit_tb.sv]
`timescale 1ns / 1ps

// Tracks pixel requests and checks the shaded pixels that come back in order.
class shaded_pixel_board;
  logic [6:0]  radius;
  logic [6:0]  thickness;
  logic [23:0] fill;
  logic [23:0] border;
  logic [23:0] background;
  logic [31:0] expected_pixels[$];
  int          errors;
  int          checked;

  function new();
    radius     = arcp_pkg::RADIUS_RST;
    thickness  = arcp_pkg::THICKNESS_RST;
    fill       = arcp_pkg::FILL_RST;
    border     = arcp_pkg::BORDER_RST;
    background = arcp_pkg::BACKGROUND_RST;
    errors     = 0;
    checked    = 0;
  endfunction

  function void set_register(logic [2:0] idx, logic [31:0] value);
    case (idx)
      arcp_pkg::REG_RADIUS:           radius = value[6:0];
      arcp_pkg::REG_RING_THICKNESS:   thickness = value[6:0];
      arcp_pkg::REG_FILL_COLOR:       fill = value[23:0];
      arcp_pkg::REG_BORDER_COLOR:     border = value[23:0];
      arcp_pkg::REG_BACKGROUND_COLOR: background = value[23:0];
      default: ;
    endcase
  endfunction

  function int eff_radius();
    int r;
    r = radius;
    if (r < 1) r = 1;
    if (r > arcp_pkg::MAX_RADIUS_DEF) r = arcp_pkg::MAX_RADIUS_DEF;
    return r;
  endfunction

  // floor(sqrt(v)); distances stay below 2^16 in q8
  function int floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return int'(root);
  endfunction

  function int coverage_at(int rim_px, int dist_q8);
    int c;
    c = rim_px * 256 + 128 - dist_q8;
    if (c < 0) c = 0;
    if (c > 256) c = 256;
    return c;
  endfunction

  function logic [23:0] blend(logic [23:0] base, logic [23:0] over, int w);
    logic [23:0] mixed;
    int          b;
    int          t;
    mixed = '0;
    for (int sh = 0; sh < 24; sh += 8) begin
      b = base[sh +: 8];
      t = over[sh +: 8];
      mixed[sh +: 8] = 8'((b * 256 + (t - b) * w + 128) >>> 8);
    end
    return mixed;
  endfunction

  function logic [31:0] shade(logic [6:0] x, logic [6:0] y);
    int              r;
    int              t;
    int              dx;
    int              dy;
    int              dist_q8;
    longint unsigned sq;
    logic [23:0]     c;
    r = eff_radius();
    t = thickness;
    if (t > r) t = r;
    // offsets in half pixels from the tile center
    dx = 2 * int'(x) + 1 - 2 * r;
    dy = 2 * int'(y) + 1 - 2 * r;
    sq = longint'(dx * dx + dy * dy);
    dist_q8 = floor_root(sq << arcp_pkg::RADICAND_SHIFT);
    c = blend(background, border, coverage_at(r, dist_q8));
    c = blend(c, fill, coverage_at(r - t, dist_q8));
    return {arcp_pkg::ALPHA, c[7:0], c[15:8], c[23:16]};
  endfunction

  function void note_pixel(logic [6:0] x, logic [6:0] y);
    expected_pixels.push_back(shade(x, y));
  endfunction

  function void check_pixel(logic [31:0] actual);
    logic [31:0] want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected pixel, expected none, actual %08h", $time, actual);
      errors++;
      return;
    end
    want = expected_pixels.pop_front();
    checked++;
    if (actual !== want) begin
      $display("%0t: pixel mismatch, expected %08h actual %08h", $time, want, actual);
      errors++;
    end
  endfunction
endclass

module antialiased_ring_tile_pixel_unit_tb;
  import arcp_pkg::*;

  localparam int         LATENCY          = 22;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         PHASE_ITEMS      = 105;
  localparam int         NUM_PHASES       = 8;
  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [6:0]        in_pixel_x;
  logic [6:0]        in_pixel_y;
  logic              out_strobe;
  logic [31:0]       out_dib_pixel;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  shaded_pixel_board board = new();
  int                idle_pct;
  int                cycles = 0;

  antialiased_ring_tile_pixel_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .out_strobe(out_strobe),
    .out_dib_pixel(out_dib_pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time,
               board.expected_pixels.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // inputs and outputs both sampled at the edge, before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_pixel(in_pixel_x, in_pixel_y);
      if (out_strobe) board.check_pixel(out_dib_pixel);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic setup_ring(input logic [31:0] r, input logic [31:0] t);
    write_reg(REG_RADIUS, r);
    write_reg(REG_RING_THICKNESS, t);
    write_reg(REG_FILL_COLOR, $urandom);
    write_reg(REG_BORDER_COLOR, $urandom);
    write_reg(REG_BACKGROUND_COLOR, $urandom);
  endtask

  task automatic send_pixel(input logic [6:0] x, input logic [6:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      in_pixel_x <= 7'($urandom);
      in_pixel_y <= 7'($urandom);
      @(posedge clk);
    end
    start      <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.expected_pixels.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_pixels(input int count);
    int         side;
    logic [6:0] x;
    logic [6:0] y;
    side = 2 * board.eff_radius();
    for (int n = 0; n < count; n++) begin
      // mostly inside the tile, some anywhere in the 7-bit range
      if ($urandom_range(99) < 85) begin
        x = 7'($urandom_range(side - 1));
        y = 7'($urandom_range(side - 1));
      end else begin
        x = 7'($urandom);
        y = 7'($urandom);
      end
      send_pixel(x, y);
    end
  endtask

  initial begin
    int r;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 27;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: corners, center, far outside the tile
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd15, 7'd15);
    send_pixel(7'd7, 7'd7);
    send_pixel(7'd8, 7'd8);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd127, 7'd0);
    send_pixel(7'd0, 7'd127);
    drain();

    // largest radius, ring covering the whole disc
    setup_ring(64, 64);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd63, 7'd63);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd64, 7'd0);
    drain();

    // zero radius acts as one, no ring
    setup_ring(0, 0);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd1, 7'd1);
    send_pixel(7'd2, 7'd0);
    drain();

    // radius above the limit, thickness above the radius
    setup_ring(127, 100);
    send_pixel(7'd0, 7'd127);
    send_pixel(7'd64, 7'd64);
    drain();

    // writes to unmapped registers must not disturb anything
    for (int i = REG_FIRST_UNUSED; i < (1 << 3); i++) write_reg(3'(i), '1);
    send_pixel(7'd3, 7'd3);
    send_pixel(7'd100, 7'd20);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = 27;
      case (ph)
        0: setup_ring(64, $urandom_range(64));
        1: setup_ring(1, 127);
        2: begin
          r = $urandom_range(1, 64);
          setup_ring(r, $urandom_range(r));
        end
        3: setup_ring(0, 0);
        4: begin
          setup_ring(127, 63);
          idle_pct = 0;
        end
        default: setup_ring($urandom_range(127), $urandom_range(127));
      endcase
      if (ph == 3) begin
        // hold off mid-stream until everything is back
        random_pixels(PHASE_ITEMS / 2);
        drain();
        random_pixels(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        random_pixels(PHASE_ITEMS);
      end
      drain();
    end

    start <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (board.expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never came back", $time, board.expected_pixels.size());
      board.errors++;
    end
    $display("Checked %0d shaded pixels over %0d ring settings,", board.checked,
             NUM_PHASES + 4);
    $display("radius 0..127 with saturation, thin to full rings, random colors.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[antialiased_ring_tile_pixel_unit.f]
rtl/arcp_pkg.sv
rtl/arcp_dist.sv
rtl/arcp_sqrt.sv
rtl/arcp_shade.sv
rtl/antialiased_ring_tile_pixel_unit.sv
tb/antialiased_ring_tile_pixel_unit_tb.sv
